FILE: hw/rtl/ist_pkg.sv
// Shared types and constants for the integer stack with frame marks.
package ist_pkg;

	// Default sizes
	localparam int unsigned STACK_DEPTH_DEF = 256;
	localparam int unsigned MARK_DEPTH_DEF  = 64;

	// Operation codes
	localparam logic [2:0] FN_PUSH    = 3'd0;
	localparam logic [2:0] FN_POP     = 3'd1;
	localparam logic [2:0] FN_PEEK    = 3'd2;
	localparam logic [2:0] FN_MARK    = 3'd3;
	localparam logic [2:0] FN_RELEASE = 3'd4;
	localparam logic [2:0] FN_FLUSH   = 3'd5;

	// Status codes
	localparam logic [1:0] ST_OK     = 2'd0;
	localparam logic [1:0] ST_EMPTY  = 2'd1;
	localparam logic [1:0] ST_FULL   = 2'd2;
	localparam logic [1:0] ST_NOMARK = 2'd3;

	// Value returned by a pop of an empty stack
	localparam logic signed [31:0] EMPTY_POP_VALUE = -32'sd99;

	// Control sequencer states
	typedef enum logic {
		IST_IDLE,
		IST_EXEC
	} ist_state_t;

endpackage

FILE: hw/rtl/ist_ram.sv
// Single-port-write, single-port-read synchronous RAM with registered read data.
module ist_ram #(
	parameter int unsigned WIDTH = 32,
	parameter int unsigned DEPTH = 256,
	parameter int unsigned AW    = 8
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (we)
			mem[waddr] <= wdata;
	end

	// read port, registered read data
	always_ff @(posedge clk) begin
		rdata <= mem[raddr];
	end

endmodule

FILE: hw/rtl/int_stack_with_frame_marks.sv
// Top level: value stack and mark stack in RAM, with the op sequencer.
// The op word is latched at the accepting edge; in the exec state the result word
// is formed and registered onto the outputs, with done high. Busy is high for the
// one cycle in which the top-of-stack RAM read completes, so no op is then taken.
// Reset clears both stack pointers and the sequencer; RAM contents are left as is.
// The receiver cannot stall: done is high for exactly one cycle per result word.
module int_stack_with_frame_marks
	#(
	parameter int unsigned STACK_DEPTH = ist_pkg::STACK_DEPTH_DEF,
	parameter int unsigned MARK_DEPTH  = ist_pkg::MARK_DEPTH_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                start,
	output logic                                busy,
	input  logic [2:0]                          func,
	input  logic signed [31:0]                  value,
	output logic                                done,
	output logic signed [31:0]                  result_value,
	output logic [1:0]                          status,
	output logic [$clog2(STACK_DEPTH+1)-1:0]    depth
);
	import ist_pkg::*;

	localparam int unsigned DW  = $clog2(STACK_DEPTH + 1);
	localparam int unsigned AW  = $clog2(STACK_DEPTH);
	localparam int unsigned MCW = $clog2(MARK_DEPTH + 1);
	localparam int unsigned MAW = $clog2(MARK_DEPTH);
	localparam logic [DW-1:0]  STACK_MAX = DW'(STACK_DEPTH);
	localparam logic [MCW-1:0] MARK_MAX  = MCW'(MARK_DEPTH);

	ist_state_t state_q, state_d;

	logic                   accept;
	logic [DW-1:0]          depth_q, depth_d;
	logic [MCW-1:0]         mcnt_q, mcnt_d;
	logic [2:0]             func_s1;
	logic signed [31:0]     value_s1;
	logic signed [31:0]     result_q, result_d;
	logic [1:0]             status_q, status_d;
	logic                   done_q, done_d;

	logic [DW-1:0]          depth_m1;
	logic [MCW-1:0]         mcnt_m1;
	logic                   v_we, m_we;
	logic [31:0]            v_rdata;
	logic [DW-1:0]          m_rdata;

	assign accept   = start && !busy;
	assign depth_m1 = depth_q - DW'(1);
	assign mcnt_m1  = mcnt_q - MCW'(1);

	// value store: read top at accept, push writes in the exec cycle
	ist_ram #(.WIDTH(32), .DEPTH(STACK_DEPTH), .AW(AW)) u_vram (
		.clk   (clk),
		.we    (v_we),
		.waddr (depth_q[AW-1:0]),
		.wdata (value_s1),
		.raddr (depth_m1[AW-1:0]),
		.rdata (v_rdata)
	);

	// mark store: holds stack depths at the time of each mark
	ist_ram #(.WIDTH(DW), .DEPTH(MARK_DEPTH), .AW(MAW)) u_mram (
		.clk   (clk),
		.we    (m_we),
		.waddr (mcnt_q[MAW-1:0]),
		.wdata (depth_q),
		.raddr (mcnt_m1[MAW-1:0]),
		.rdata (m_rdata)
	);

	// sequencer state and pointers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= IST_IDLE;
			depth_q <= '0;
			mcnt_q  <= '0;
			done_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			depth_q <= depth_d;
			mcnt_q  <= mcnt_d;
			done_q  <= done_d;
		end
	end

	// op word latch and result word register
	always_ff @(posedge clk) begin
		if (accept) begin
			func_s1  <= func;
			value_s1 <= value;
		end
		result_q <= result_d;
		status_q <= status_d;
	end

	// next state, pointer update and result
	always_comb begin
		state_d  = state_q;
		depth_d  = depth_q;
		mcnt_d   = mcnt_q;
		done_d   = 1'b0;
		result_d = result_q;
		status_d = status_q;
		v_we     = 1'b0;
		m_we     = 1'b0;
		busy     = 1'b0;
		unique case (state_q)
			IST_IDLE: begin
				if (start)
					state_d = IST_EXEC;
			end
			IST_EXEC: begin
				busy     = 1'b1;
				state_d  = IST_IDLE;
				done_d   = 1'b1;
				result_d = '0;
				status_d = ST_OK;
				unique case (func_s1)
					FN_PUSH: begin
						if (depth_q < STACK_MAX) begin
							v_we    = 1'b1;
							depth_d = depth_q + DW'(1);
						end else begin
							status_d = ST_FULL;
						end
					end
					FN_POP: begin
						if (depth_q != '0) begin
							depth_d  = depth_m1;
							result_d = v_rdata;
						end else begin
							result_d = EMPTY_POP_VALUE;
							status_d = ST_EMPTY;
						end
					end
					FN_PEEK: begin
						if (depth_q != '0) begin
							result_d = v_rdata;
						end else begin
							result_d = value_s1;
							status_d = ST_EMPTY;
						end
					end
					FN_MARK: begin
						if (mcnt_q < MARK_MAX) begin
							m_we   = 1'b1;
							mcnt_d = mcnt_q + MCW'(1);
						end else begin
							status_d = ST_FULL;
						end
					end
					FN_RELEASE: begin
						if (mcnt_q != '0) begin
							mcnt_d = mcnt_m1;
							if (m_rdata < depth_q)
								depth_d = m_rdata;
						end else begin
							status_d = ST_NOMARK;
						end
					end
					FN_FLUSH: begin
						depth_d = '0;
						mcnt_d  = '0;
					end
					default: begin
					end
				endcase
			end
			default: begin
				state_d = IST_IDLE;
			end
		endcase
	end

	assign done         = done_q;
	assign result_value = result_q;
	assign status       = status_q;
	assign depth        = depth_q;

endmodule
